>>> hw/rtl/brc_pkg.sv
// shared types and codes for the barcode row consistency checker
package brc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_QUIET_MARGIN = 2'd2;
	localparam logic [1:0] REG_MODULE_WIDTH = 2'd3;

	// result kinds
	localparam logic KIND_BAR    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_ERROR  = 2'd1;
	localparam logic [1:0] STATUS_LAYOUT = 2'd2;

	// queue between classification and output sequencing
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QLW    = $clog2(QDEPTH + 1);

	// configuration register set
	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [10:0] quiet_margin;
		logic [5:0]  module_width;
	} cfg_t;

	// one queue entry: the results caused by one pixel
	typedef struct packed {
		logic       has_bar;
		logic [6:0] bar_index;
		logic       bar_value;
		logic       has_status;
		logic [1:0] status;
	} entry_t;

endpackage

>>> hw/rtl/brc_front.sv
// pixel classification: raster counters, reference store and sticky error
module brc_front
	import brc_pkg::*;
#(
	parameter int BARS_PER_ROW = 67,
	parameter int MAX_DIM      = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_t           cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           pixel,
	input  logic [QLW-1:0] q_level,
	output logic           push,
	output entry_t         push_entry
);

	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int CW    = (DW > 13) ? DW : 13;
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int BAR_W = $clog2(BARS_PER_ROW + 1);
	localparam int IDX_W = (BARS_PER_ROW > 1) ? $clog2(BARS_PER_ROW) : 1;
	localparam int NW    = $clog2(BARS_PER_ROW * 63 + 2 * 2047 + 1);
	localparam int LW    = (NW > CW) ? NW : CW;

	logic [CNT_W-1:0] col_q, row_q;
	logic [5:0]       phase_q;
	logic [BAR_W-1:0] bar_q;
	logic             err_q;
	logic             ref_mem [BARS_PER_ROW];

	logic             v_s1, px_s1, rd_s1, zero_chk_s1, ref_chk_s1, smp_s1, final_s1;
	logic [BAR_W-1:0] bar_s1;

	logic             accept;
	logic [CW-1:0]    w_e, h_e, m_x, col_x, row_x, col_e, row_e;
	logic [CW:0]      row_plus_m;
	logic [5:0]       mw_e, phase_c, phase_inc;
	logic [BAR_W-1:0] bar_c;
	logic             checked, ref_row, in_margin, active, mod_start;
	logic             zero_chk, ref_chk, smp, row_end, img_end;
	logic [5:0]       phase_n;
	logic [BAR_W-1:0] bar_n;
	logic [CNT_W-1:0] col_n, row_n;
	logic [IDX_W-1:0] idx;

	logic [LW-1:0]    need, w_l;
	logic             layout_bad, err_now;

	// credit check against queue room, counting the pixel in flight
	assign in_stall = (QLW'(q_level + QLW'(v_s1))) >= QLW'(QDEPTH);
	assign accept   = in_valid && !in_stall;

	// effective register values
	always_comb begin
		w_e = CW'(cfg.image_width);
		if (w_e == '0) w_e = CW'(1);
		else if (w_e > CW'(MAX_DIM)) w_e = CW'(MAX_DIM);
		h_e = CW'(cfg.image_height);
		if (h_e == '0) h_e = CW'(1);
		else if (h_e > CW'(MAX_DIM)) h_e = CW'(MAX_DIM);
		mw_e = (cfg.module_width == '0) ? 6'd1 : cfg.module_width;
		m_x  = CW'(cfg.quiet_margin);
	end

	// classify the incoming pixel against the counters
	always_comb begin
		col_x      = CW'(col_q);
		row_x      = CW'(row_q);
		row_plus_m = {1'b0, row_x} + {1'b0, m_x};
		checked    = (row_x >= m_x) && (row_plus_m < {1'b0, h_e});
		ref_row    = (row_x == m_x);
		col_e      = (col_x >= w_e) ? w_e - CW'(1) : col_x;
		row_e      = (row_x >= h_e) ? h_e - CW'(1) : row_x;
		bar_c      = (col_e == '0) ? '0 : bar_q;
		phase_c    = (col_e == '0) ? '0 : phase_q;
		in_margin  = col_e < m_x;
		active     = bar_c < BAR_W'(BARS_PER_ROW);
		mod_start  = !in_margin && active && (phase_c == '0);
		zero_chk   = checked && (in_margin || !active);
		ref_chk    = checked && !ref_row && mod_start;
		smp        = ref_row && mod_start;
		idx        = bar_c[IDX_W-1:0];
		phase_inc  = phase_c + 6'd1;
		phase_n    = phase_c;
		bar_n      = bar_c;
		if (!in_margin && active) begin
			if (phase_inc >= mw_e) begin
				phase_n = '0;
				bar_n   = bar_c + BAR_W'(1);
			end else begin
				phase_n = phase_inc;
			end
		end
		row_end = (col_e + CW'(1)) >= w_e;
		img_end = row_end && ((row_e + CW'(1)) >= h_e);
		col_n   = row_end ? '0 : CNT_W'(col_e + CW'(1));
		if (!row_end) row_n = CNT_W'(row_e);
		else if (img_end) row_n = '0;
		else row_n = CNT_W'(row_e + CW'(1));
		if (row_end) begin
			phase_n = '0;
			bar_n   = '0;
		end
	end

	// counters and the first pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
			bar_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				col_q   <= col_n;
				row_q   <= row_n;
				phase_q <= phase_n;
				bar_q   <= bar_n;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= pixel;
			zero_chk_s1 <= zero_chk;
			ref_chk_s1  <= ref_chk;
			smp_s1      <= smp;
			final_s1    <= img_end;
			bar_s1      <= bar_c;
		end
	end

	// reference store, read with a registered port
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= ref_mem[idx];
			if (smp) ref_mem[idx] <= pixel;
		end
	end

	// layout check and error accumulation
	always_comb begin
		need       = LW'(BARS_PER_ROW) * LW'(mw_e) + LW'({cfg.quiet_margin, 1'b0});
		w_l        = LW'(w_e);
		layout_bad = (need > w_l) || (m_x >= h_e);
		err_now    = err_q || (zero_chk_s1 && px_s1) || (ref_chk_s1 && (rd_s1 != px_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (v_s1) begin
			err_q <= final_s1 ? 1'b0 : err_now;
		end
	end

	// hand the results of this pixel to the queue
	always_comb begin
		push                  = v_s1 && (smp_s1 || final_s1);
		push_entry.has_bar    = smp_s1;
		push_entry.bar_index  = 7'(bar_s1);
		push_entry.bar_value  = px_s1;
		push_entry.has_status = final_s1;
		if (layout_bad) push_entry.status = STATUS_LAYOUT;
		else if (err_now) push_entry.status = STATUS_ERROR;
		else push_entry.status = STATUS_OK;
	end

endmodule

>>> hw/rtl/brc_queue.sv
// small entry queue between classification and output sequencing
module brc_queue
	import brc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  entry_t         push_entry,
	input  logic           pop,
	output logic           head_valid,
	output entry_t         head,
	output logic [QLW-1:0] level
);

	entry_t           mem_q [QDEPTH];
	logic [QPW-1:0]   wr_q, rd_q;
	logic [QLW-1:0]   count_q;

	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign level      = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPW'(1);
			if (pop) rd_q <= rd_q + QPW'(1);
			count_q <= count_q + QLW'(push) - QLW'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

endmodule

>>> hw/rtl/brc_back.sv
// output sequencer: turns queue entries into one or two result requests
module brc_back
	import brc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [6:0] bar_index,
	output logic       bar_value,
	output logic [1:0] status,
	output logic       last
);

	logic       out_valid_q, part_q, load, bar_part;
	logic       kind_q, bar_value_q, last_q;
	logic [6:0] bar_index_q;
	logic [1:0] status_q;

	// bar sample goes out first, status after it
	assign load     = head_valid && (!out_valid_q || !out_stall);
	assign bar_part = head.has_bar && !part_q;
	assign pop      = load && (!bar_part || !head.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			part_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			part_q      <= bar_part && head.has_status;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (bar_part) begin
				kind_q      <= KIND_BAR;
				bar_index_q <= head.bar_index;
				bar_value_q <= head.bar_value;
				status_q    <= STATUS_OK;
				last_q      <= !head.has_status;
			end else begin
				kind_q      <= KIND_STATUS;
				bar_index_q <= '0;
				bar_value_q <= 1'b0;
				status_q    <= head.status;
				last_q      <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign bar_index = bar_index_q;
	assign bar_value = bar_value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

>>> hw/rtl/barcode_row_consistency_checker_top.sv
// top level: configuration registers, classifier, queue and output sequencer
// path: a pixel's results pass the first pipeline stage, the queue and the output register
// throughput: one pixel per cycle while in_stall is low; the counters and one reference compare set the pace
// a final pixel that also samples a bar yields two result requests, the bar sample first
// reset: asynchronous, clears counters, error flag, queue and registers to defaults
// the reference bar store is not cleared; the reference row writes it before any read
module barcode_row_consistency_checker_top
	import brc_pkg::*;
#(
	parameter int BARS_PER_ROW = 67,
	parameter int MAX_DIM      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [6:0]  bar_index,
	output logic        bar_value,
	output logic [1:0]  status,
	output logic        last
);

	cfg_t           cfg_q;
	logic           push, pop, head_valid;
	entry_t         push_entry, head;
	logic [QLW-1:0] q_level;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'd4096;
			cfg_q.image_height <= 13'd4096;
			cfg_q.quiet_margin <= '0;
			cfg_q.module_width <= 6'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				REG_QUIET_MARGIN: cfg_q.quiet_margin <= cfg_data[10:0];
				REG_MODULE_WIDTH: cfg_q.module_width <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	brc_front #(
		.BARS_PER_ROW(BARS_PER_ROW),
		.MAX_DIM     (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.q_level   (q_level),
		.push      (push),
		.push_entry(push_entry)
	);

	brc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.level     (q_level)
	);

	brc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.bar_index (bar_index),
		.bar_value (bar_value),
		.status    (status),
		.last      (last)
	);

endmodule
